@@ rtl/pidd_pkg.sv @@
// ----------------------------------------------------------------------------
// pidd_pkg: shared types, constants and arithmetic helpers
// Q16.16 formats, function codes, register map, filter coefficients.
// ----------------------------------------------------------------------------
package pidd_pkg;

   // sample period and derivative filter time constant, Q16.16
   localparam longint SAMPLE_PERIOD_Q16 = 655;
   localparam longint FILTER_TIME_Q16   = 3277;

   localparam longint FILT_DEN  = 2 * FILTER_TIME_Q16 + SAMPLE_PERIOD_Q16;
   localparam longint BETA_NUM  = (2 * FILTER_TIME_Q16 - SAMPLE_PERIOD_Q16) * 65536;
   localparam longint BETA_ABS  = (BETA_NUM < 0) ? -BETA_NUM : BETA_NUM;
   localparam longint BETA_MAG  = (2 * BETA_ABS + FILT_DEN) / (2 * FILT_DEN);
   localparam longint BETA_VAL  = (BETA_NUM < 0) ? -BETA_MAG : BETA_MAG;
   localparam longint GAIN_RAW  = ((longint'(1) << 34) + FILT_DEN) / (2 * FILT_DEN);
   localparam longint GAIN_VAL  = (GAIN_RAW > 2147483647) ? 2147483647 : GAIN_RAW;

   typedef logic signed [31:0] word_type;
   typedef logic signed [32:0] opnd_type;
   typedef logic signed [65:0] prod_type;

   localparam opnd_type TS_OPND        = 33'(SAMPLE_PERIOD_Q16);
   localparam opnd_type BETA_OPND      = 33'(BETA_VAL);
   localparam opnd_type RATE_GAIN_OPND = 33'(GAIN_VAL);

   localparam prod_type SAT_HI = 66'sd2147483647;
   localparam prod_type SAT_LO = -66'sd2147483648;

   localparam logic [1:0] FUNC_PID   = 2'd0;
   localparam logic [1:0] FUNC_PD    = 2'd1;
   localparam logic [1:0] FUNC_RESET = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   localparam logic [2:0] REG_GAIN_PROP     = 3'd0;
   localparam logic [2:0] REG_GAIN_INTEGRAL = 3'd1;
   localparam logic [2:0] REG_GAIN_DERIV    = 3'd2;
   localparam logic [2:0] REG_OUT_MIN       = 3'd3;
   localparam logic [2:0] REG_OUT_MAX       = 3'd4;
   localparam logic [2:0] REG_DEAD_LOW      = 3'd5;
   localparam logic [2:0] REG_DEAD_HIGH     = 3'd6;
   localparam logic [2:0] REG_MODE          = 3'd7;

   localparam int CSR_ADDR_W = 5;

   localparam word_type OUT_MIN_RESET = 32'sh8000_0000;
   localparam word_type OUT_MAX_RESET = 32'sh7fff_ffff;

   typedef struct packed {
      word_type   gain_prop;
      word_type   gain_integral;
      word_type   gain_deriv;
      word_type   out_min;
      word_type   out_max;
      word_type   dead_low;
      word_type   dead_high;
      logic [1:0] mode_bits;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic        neg;
      logic [63:0] num_mag;
      logic [31:0] den_mag;
   } div_req_type;

   function automatic prod_type wide(input word_type w);
      return {{34{w[31]}}, w};
   endfunction

   function automatic word_type sat32(input prod_type v);
      word_type r;
      if (v > SAT_HI) begin
         r = 32'sh7fff_ffff;
      end else if (v < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // round to nearest, ties up, then drop 16 fraction bits
   function automatic prod_type qmul(input prod_type p);
      return (p + 66'sd32768) >>> 16;
   endfunction

   function automatic word_type limit(input word_type u, input word_type lo,
                                      input word_type hi);
      word_type v;
      v = (u < hi) ? u : hi;
      return (v > lo) ? v : lo;
   endfunction

   function automatic logic [63:0] mag64(input prod_type p);
      prod_type m;
      m = p[65] ? -p : p;
      return m[63:0];
   endfunction

   function automatic logic [31:0] mag32(input word_type w);
      logic [31:0] v;
      v = w;
      return v[31] ? (~v + 32'd1) : v;
   endfunction

endpackage

@@ rtl/pidd_csr.sv @@
// ----------------------------------------------------------------------------
// pidd_csr: configuration register file
// APB-style write and read access to gains, limits, deadband and mode.
// ----------------------------------------------------------------------------
module pidd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pidd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output pidd_pkg::cfg_type                cfg
);

   pidd_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [2:0]        idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            pidd_pkg::REG_GAIN_PROP:     cfg_in.gain_prop     = csr_pwdata;
            pidd_pkg::REG_GAIN_INTEGRAL: cfg_in.gain_integral = csr_pwdata;
            pidd_pkg::REG_GAIN_DERIV:    cfg_in.gain_deriv    = csr_pwdata;
            pidd_pkg::REG_OUT_MIN:       cfg_in.out_min       = csr_pwdata;
            pidd_pkg::REG_OUT_MAX:       cfg_in.out_max       = csr_pwdata;
            pidd_pkg::REG_DEAD_LOW:      cfg_in.dead_low      = csr_pwdata;
            pidd_pkg::REG_DEAD_HIGH:     cfg_in.dead_high     = csr_pwdata;
            pidd_pkg::REG_MODE:          cfg_in.mode_bits     = csr_pwdata[1:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         pidd_pkg::REG_GAIN_PROP:     csr_prdata = cfg_ff.gain_prop;
         pidd_pkg::REG_GAIN_INTEGRAL: csr_prdata = cfg_ff.gain_integral;
         pidd_pkg::REG_GAIN_DERIV:    csr_prdata = cfg_ff.gain_deriv;
         pidd_pkg::REG_OUT_MIN:       csr_prdata = cfg_ff.out_min;
         pidd_pkg::REG_OUT_MAX:       csr_prdata = cfg_ff.out_max;
         pidd_pkg::REG_DEAD_LOW:      csr_prdata = cfg_ff.dead_low;
         pidd_pkg::REG_DEAD_HIGH:     csr_prdata = cfg_ff.dead_high;
         pidd_pkg::REG_MODE:          csr_prdata = {30'd0, cfg_ff.mode_bits};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop     <= '0;
         cfg_ff.gain_integral <= '0;
         cfg_ff.gain_deriv    <= '0;
         cfg_ff.out_min       <= pidd_pkg::OUT_MIN_RESET;
         cfg_ff.out_max       <= pidd_pkg::OUT_MAX_RESET;
         cfg_ff.dead_low      <= '0;
         cfg_ff.dead_high     <= '0;
         cfg_ff.mode_bits     <= 2'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/pidd_div.sv @@
// ----------------------------------------------------------------------------
// pidd_div: iterative signed divider
// Restoring division of a 64-bit magnitude by a 32-bit magnitude, two quotient
// bits per cycle, rounded half away from zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module pidd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pidd_pkg::div_req_type dreq,
   output logic                  done,
   output pidd_pkg::word_type    quot
);

   typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_ROUND, DV_DONE} dv_state_type;

   dv_state_type state_ff, state_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic [32:0]  rem_ff, rem_in;
   logic [63:0]  num_ff, num_in;
   logic [31:0]  den_ff, den_in;
   logic         neg_ff, neg_in;
   logic [64:0]  q_ff, q_in;
   logic [32:0]  r_step;
   logic [63:0]  n_step;

   // two restoring steps; quotient bits enter at the bottom of num
   always_comb begin
      r_step = rem_ff;
      n_step = num_ff;
      for (int k = 0; k < 2; k++) begin
         r_step = {r_step[31:0], n_step[63]};
         n_step = {n_step[62:0], 1'b0};
         if (r_step >= {1'b0, den_ff}) begin
            r_step    = r_step - {1'b0, den_ff};
            n_step[0] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      q_in     = q_ff;
      case (state_ff)
         DV_IDLE: begin
            if (dreq.start) begin
               num_in   = dreq.num_mag;
               den_in   = dreq.den_mag;
               neg_in   = dreq.neg;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in = r_step;
            num_in = n_step;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = DV_ROUND;
            end
         end
         DV_ROUND: begin
            q_in     = {1'b0, num_ff} + {64'd0, ({rem_ff, 1'b0} >= {2'b00, den_ff})};
            state_in = DV_DONE;
         end
         DV_DONE: state_in = DV_IDLE;
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
   end

   assign done = (state_ff == DV_DONE);

   always_comb begin
      if (neg_ff) begin
         quot = (q_ff > 65'h0_8000_0000) ? 32'sh8000_0000 : (~q_ff[31:0] + 32'd1);
      end else begin
         quot = (q_ff > 65'h0_7fff_ffff) ? 32'sh7fff_ffff : q_ff[31:0];
      end
   end

endmodule

@@ rtl/pidd_seq.sv @@
// ----------------------------------------------------------------------------
// pidd_seq: controller sequencer and shared multiplier
// Steps one request through integrator, anti-windup, rate filter, term sum,
// limits and deadband, using one registered 33x33 multiplier and the divider.
// ----------------------------------------------------------------------------
module pidd_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  pidd_pkg::cfg_type      cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  pidd_pkg::word_type     req_setpoint,
   input  pidd_pkg::word_type     req_measured,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pidd_pkg::word_type     rsp_drive,
   output pidd_pkg::div_req_type  dreq,
   input  logic                   div_done,
   input  pidd_pkg::word_type     div_quot
);

   typedef enum logic [4:0] {
      S_IDLE, S_INT, S_INT_ACC, S_AW_MUL, S_AW_DIV, S_AW_WAIT, S_KP, S_KI, S_RB,
      S_RG, S_RD, S_KD, S_SUM, S_LIM, S_DB_MUL, S_DB_DIV, S_DB_WAIT, S_OUT
   } seq_state_type;

   seq_state_type      state_ff, state_in;
   logic [1:0]         func_ff, func_in;
   pidd_pkg::word_type err_ff, err_in;
   pidd_pkg::word_type meas_ff, meas_in;
   pidd_pkg::word_type integ_ff, integ_in;
   pidd_pkg::word_type prev_err_ff, prev_err_in;
   pidd_pkg::word_type prev_meas_ff, prev_meas_in;
   pidd_pkg::word_type err_rate_ff, err_rate_in;
   pidd_pkg::word_type meas_rate_ff, meas_rate_in;
   pidd_pkg::word_type drive_ff, drive_in;
   pidd_pkg::prod_type acc_ff, acc_in;
   pidd_pkg::prod_type tmp_ff, tmp_in;
   pidd_pkg::prod_type prod_ff;
   pidd_pkg::opnd_type mul_a, mul_b;

   logic               pid, on_error, pos;
   pidd_pkg::word_type rate_sel, delta, t_aw, u_lim, dead_sel, den_sel;

   assign pid      = (func_ff == pidd_pkg::FUNC_PID);
   assign on_error = cfg.mode_bits[0];
   assign rate_sel = on_error ? err_rate_ff : meas_rate_ff;
   assign delta    = on_error
                   ? pidd_pkg::sat32(pidd_pkg::wide(err_ff) - pidd_pkg::wide(prev_err_ff))
                   : pidd_pkg::sat32(pidd_pkg::wide(meas_ff) - pidd_pkg::wide(prev_meas_ff));
   assign t_aw     = pidd_pkg::limit(pidd_pkg::sat32(pidd_pkg::qmul(prod_ff)),
                                     cfg.out_min, cfg.out_max);
   assign u_lim    = pidd_pkg::limit(pidd_pkg::sat32(acc_ff), cfg.out_min, cfg.out_max);
   assign pos      = !drive_ff[31];
   assign dead_sel = pos ? cfg.dead_high : cfg.dead_low;
   assign den_sel  = pos ? cfg.out_max : cfg.out_min;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_drive = drive_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_INT: begin
            mul_a = pidd_pkg::TS_OPND;
            mul_b = {err_ff[31], err_ff} + {prev_err_ff[31], prev_err_ff};
         end
         S_AW_MUL: begin
            mul_a = {cfg.gain_integral[31], cfg.gain_integral};
            mul_b = {integ_ff[31], integ_ff};
         end
         S_KP: begin
            mul_a = {cfg.gain_prop[31], cfg.gain_prop};
            mul_b = {err_ff[31], err_ff};
         end
         S_KI: begin
            mul_a = {cfg.gain_integral[31], cfg.gain_integral};
            mul_b = {integ_ff[31], integ_ff};
         end
         S_RB: begin
            mul_a = pidd_pkg::BETA_OPND;
            mul_b = {rate_sel[31], rate_sel};
         end
         S_RG: begin
            mul_a = pidd_pkg::RATE_GAIN_OPND;
            mul_b = {delta[31], delta};
         end
         S_KD: begin
            mul_a = {cfg.gain_deriv[31], cfg.gain_deriv};
            mul_b = {rate_sel[31], rate_sel};
         end
         S_DB_MUL: begin
            mul_a = {drive_ff[31], drive_ff};
            mul_b = {den_sel[31], den_sel} - {dead_sel[31], dead_sel};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      err_in       = err_ff;
      meas_in      = meas_ff;
      integ_in     = integ_ff;
      prev_err_in  = prev_err_ff;
      prev_meas_in = prev_meas_ff;
      err_rate_in  = err_rate_ff;
      meas_rate_in = meas_rate_ff;
      drive_in     = drive_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      dreq         = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               err_in  = pidd_pkg::sat32(pidd_pkg::wide(req_setpoint)
                                         - pidd_pkg::wide(req_measured));
               meas_in = req_measured;
               case (req_func)
                  pidd_pkg::FUNC_RESET: begin
                     integ_in    = '0;
                     err_rate_in = '0;
                     prev_err_in = pidd_pkg::sat32(pidd_pkg::wide(req_setpoint)
                                                   - pidd_pkg::wide(req_measured));
                  end
                  pidd_pkg::FUNC_NONE: state_in = S_IDLE;
                  default:             state_in = S_INT;
               endcase
            end
         end
         S_INT: state_in = S_INT_ACC;
         S_INT_ACC: begin
            integ_in = pidd_pkg::sat32(pidd_pkg::wide(integ_ff)
                                       + ((prod_ff + 66'sd65536) >>> 17));
            if (pid && cfg.mode_bits[1] && (cfg.gain_integral != 32'sd0)) begin
               state_in = S_AW_MUL;
            end else begin
               state_in = S_KP;
            end
         end
         S_AW_MUL: state_in = S_AW_DIV;
         S_AW_DIV: begin
            dreq.start   = 1'b1;
            dreq.neg     = t_aw[31] ^ cfg.gain_integral[31];
            dreq.num_mag = pidd_pkg::mag64(pidd_pkg::wide(t_aw) <<< 16);
            dreq.den_mag = pidd_pkg::mag32(cfg.gain_integral);
            state_in     = S_AW_WAIT;
         end
         S_AW_WAIT: begin
            if (div_done) begin
               integ_in = div_quot;
               state_in = S_KP;
            end
         end
         S_KP: state_in = S_KI;
         S_KI: begin
            acc_in   = pidd_pkg::qmul(prod_ff);
            state_in = S_RB;
         end
         S_RB: begin
            if (pid) begin
               acc_in = acc_ff + pidd_pkg::qmul(prod_ff);
            end
            state_in = S_RG;
         end
         S_RG: begin
            tmp_in   = pidd_pkg::qmul(prod_ff);
            state_in = S_RD;
         end
         S_RD: begin
            if (on_error) begin
               err_rate_in  = pidd_pkg::sat32(tmp_ff + pidd_pkg::qmul(prod_ff));
            end else begin
               meas_rate_in = pidd_pkg::sat32(tmp_ff + pidd_pkg::qmul(prod_ff));
            end
            state_in = S_KD;
         end
         S_KD: state_in = S_SUM;
         S_SUM: begin
            acc_in   = on_error ? acc_ff + pidd_pkg::qmul(prod_ff)
                                : acc_ff - pidd_pkg::qmul(prod_ff);
            state_in = S_LIM;
         end
         S_LIM: begin
            prev_err_in  = err_ff;
            prev_meas_in = meas_ff;
            drive_in     = u_lim;
            state_in     = S_OUT;
            if (pid) begin
               // zero drive passes; a zero limit gives the bare deadband offset
               if (u_lim == 32'sd0) begin
                  drive_in = '0;
               end else if (!u_lim[31] && (cfg.out_max == 32'sd0)) begin
                  drive_in = cfg.dead_high;
               end else if (u_lim[31] && (cfg.out_min == 32'sd0)) begin
                  drive_in = cfg.dead_low;
               end else begin
                  state_in = S_DB_MUL;
               end
            end
         end
         S_DB_MUL: state_in = S_DB_DIV;
         S_DB_DIV: begin
            dreq.start   = 1'b1;
            dreq.neg     = prod_ff[65] ^ den_sel[31];
            dreq.num_mag = pidd_pkg::mag64(prod_ff);
            dreq.den_mag = pidd_pkg::mag32(den_sel);
            state_in     = S_DB_WAIT;
         end
         S_DB_WAIT: begin
            if (div_done) begin
               drive_in = pidd_pkg::sat32(pidd_pkg::wide(dead_sel) + pidd_pkg::wide(div_quot));
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         integ_ff     <= '0;
         prev_err_ff  <= '0;
         prev_meas_ff <= '0;
         err_rate_ff  <= '0;
         meas_rate_ff <= '0;
      end else begin
         state_ff     <= state_in;
         integ_ff     <= integ_in;
         prev_err_ff  <= prev_err_in;
         prev_meas_ff <= prev_meas_in;
         err_rate_ff  <= err_rate_in;
         meas_rate_ff <= meas_rate_in;
      end
      func_ff  <= func_in;
      err_ff   <= err_in;
      meas_ff  <= meas_in;
      drive_ff <= drive_in;
      acc_ff   <= acc_in;
      tmp_ff   <= tmp_in;
      prod_ff  <= pidd_pkg::prod_type'(mul_a) * pidd_pkg::prod_type'(mul_b);
   end

endmodule

@@ rtl/pid_controller_dirty_derivative_top.sv @@
// ----------------------------------------------------------------------------
// pid_controller_dirty_derivative_top: Q16.16 PID controller
// PID/PD step with trapezoidal integrator, filtered derivative, anti-windup
// and deadband compensation.
// ----------------------------------------------------------------------------
// Usage:
//  Requests arrive on req_* (valid/ready): func, setpoint, measured. A PID or
//  PD step gives one drive value on rsp_* (valid/ready). A setpoint reset
//  updates state at acceptance, the unused code is dropped, and neither gives
//  a result.
//  Gains, limits, deadband and mode are written through the csr_* APB port;
//  the user must write them only while no request is in flight, which the
//  block does not enforce. pready is tied high. A PID step may also run the
//  divider for anti-windup and for deadband; a PD step never does. The
//  divider retires two quotient bits a cycle and the single multiplier
//  serves one product a cycle; these set the rate.
//  One request is in flight at a time: req_ready is low from acceptance
//  until the result is taken. A stalled receiver holds rsp_valid and
//  rsp_drive steady. Reset clears the controller state and loads register
//  defaults (limits at full range, gains zero).
// ----------------------------------------------------------------------------
module pid_controller_dirty_derivative_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_func,
   input  logic signed [31:0]               req_setpoint,
   input  logic signed [31:0]               req_measured,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [31:0]               rsp_drive,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pidd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   pidd_pkg::cfg_type     cfg;
   pidd_pkg::div_req_type dreq;
   logic                  div_done;
   pidd_pkg::word_type    div_quot;

   pidd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pidd_div u_div (
      .clock (clock),
      .reset (reset),
      .dreq  (dreq),
      .done  (div_done),
      .quot  (div_quot)
   );

   pidd_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_drive    (rsp_drive),
      .dreq         (dreq),
      .div_done     (div_done),
      .div_quot     (div_quot)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_ready |=> req_ready)
      else $error("not ready after result delivered");

   assert property (@(posedge clock) disable iff (reset)
                    req_valid && req_ready && req_func == pidd_pkg::FUNC_RESET
                    |=> req_ready && !rsp_valid)
      else $error("setpoint reset produced a result or stalled");

   assert property (@(posedge clock) disable iff (reset)
                    dreq.start |-> !div_done)
      else $error("divider started while finishing");
`endif

endmodule
